// ===== rtl/core/kmpd_pkg.sv =====
// ---------------------------------------------------------------------------
// kmpd_pkg: shared constants and types for the key matrix press detector
// Matrix geometry, field widths and the per-scan result struct.
// ---------------------------------------------------------------------------
package kmpd_pkg;

  // matrix geometry
  localparam int COLUMNS   = 16;
  localparam int ROW_COUNT = 5;

  // fixed field widths
  localparam int ROW_W     = 5;   // row sample field
  localparam int COL_W     = 4;   // column number inside a key code
  localparam int ROW_IDX_W = 3;   // row number inside a key code
  localparam int CODE_W    = ROW_IDX_W + COL_W;

  // rows actually compared and stored
  localparam int ROWS_USED = (ROW_COUNT < ROW_W) ? ROW_COUNT : ROW_W;

  // last column of a scan
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  // one scan result
  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } kmpd_result_t;

endpackage

// ===== rtl/core/key_matrix_press_detector.sv =====
// ---------------------------------------------------------------------------
// key_matrix_press_detector: key matrix new-press detector
// Takes one row sample per column beat, reports one result per full scan.
// ---------------------------------------------------------------------------
// Throughput: one column beat per cycle while in_ready is high; one result every COLUMNS beats.
// The result is registered and appears in the cycle after the last column's beat.
// The previous-scan store is a ring of COLUMNS cells that shifts on each beat.
// Input stalls only while a finished result waits and out_ready is low.
// Reset (synchronous, rst_n low) clears the ring, column count and scan state; not the output data.
module key_matrix_press_detector (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kmpd_pkg::ROW_W-1:0]   in_row_bits,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_key_found,
  output logic [kmpd_pkg::CODE_W-1:0]  out_key_code
);

  logic                           beat;
  logic                           last_col;
  logic [kmpd_pkg::ROWS_USED-1:0] cur_rows;
  logic [kmpd_pkg::ROWS_USED-1:0] ring_q [kmpd_pkg::COLUMNS];
  logic [kmpd_pkg::ROWS_USED-1:0] ring_d [kmpd_pkg::COLUMNS];
  kmpd_pkg::kmpd_result_t         result;
  logic                           out_valid_r, out_valid_nxt;
  kmpd_pkg::kmpd_result_t         out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign beat     = in_valid && in_ready;
  assign cur_rows = in_row_bits[kmpd_pkg::ROWS_USED-1:0];

  // ring: head cell holds the current column, new sample enters at the tail
  for (genvar i = 0; i < kmpd_pkg::COLUMNS; i++) begin : g_ring
    if (i == kmpd_pkg::COLUMNS - 1) begin : g_tail
      assign ring_d[i] = cur_rows;
    end else begin : g_mid
      assign ring_d[i] = ring_q[i+1];
    end
    kmpd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (beat),
      .d        (ring_d[i]),
      .q        (ring_q[i])
    );
  end

  kmpd_detect u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .cur_rows  (cur_rows),
    .prev_rows (ring_q[0]),
    .last_col  (last_col),
    .result    (result)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (beat && last_col) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && last_col) begin
      out_data_r <= result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_found = out_data_r.found;
  assign out_key_code  = out_data_r.code;

`ifndef ASSERT_OFF
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && last_col) |=> out_valid_r)
    else $error("last column beat did not produce a result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && !last_col && !out_valid_r) |=> !out_valid_r)
    else $error("result produced mid-scan");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_code_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.found || out_data_r.code == '0))
    else $error("nonzero key code without a new press");
`endif

endmodule

// ===== rtl/core/kmpd_cell.sv =====
// ---------------------------------------------------------------------------
// kmpd_cell: one stage of the previous-scan ring
// Holds the row bits of one column from the last scan; shifts on each beat.
// ---------------------------------------------------------------------------
module kmpd_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             shift_en,
  input  logic [kmpd_pkg::ROWS_USED-1:0]   d,
  output logic [kmpd_pkg::ROWS_USED-1:0]   q
);

  logic [kmpd_pkg::ROWS_USED-1:0] rows_r;
  logic [kmpd_pkg::ROWS_USED-1:0] rows_nxt;

  // take the neighbor's value on each accepted beat
  always_comb begin
    rows_nxt = shift_en ? d : rows_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
    end else begin
      rows_r <= rows_nxt;
    end
  end

  assign q = rows_r;

endmodule

// ===== rtl/core/kmpd_detect.sv =====
// ---------------------------------------------------------------------------
// kmpd_detect: new-press detection and per-scan tracking
// Compares a column sample with the stored one, keeps the column count and
// the last new press of the running scan, and forms the scan result.
// ---------------------------------------------------------------------------
module kmpd_detect (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            beat,
  input  logic [kmpd_pkg::ROWS_USED-1:0]  cur_rows,
  input  logic [kmpd_pkg::ROWS_USED-1:0]  prev_rows,
  output logic                            last_col,
  output kmpd_pkg::kmpd_result_t          result
);

  logic [kmpd_pkg::COL_W-1:0]     col_r, col_nxt;
  logic                           found_r, found_nxt;
  logic [kmpd_pkg::CODE_W-1:0]    code_r, code_nxt;
  logic [kmpd_pkg::ROWS_USED-1:0] fresh;
  logic                           hit;
  logic [kmpd_pkg::ROW_IDX_W-1:0] hit_row;

  // rising bits; highest row wins
  always_comb begin
    fresh   = cur_rows & ~prev_rows;
    hit     = 1'b0;
    hit_row = '0;
    for (int r = 0; r < kmpd_pkg::ROWS_USED; r++) begin
      if (fresh[r]) begin
        hit     = 1'b1;
        hit_row = kmpd_pkg::ROW_IDX_W'(r);
      end
    end
  end

  assign last_col = (col_r == kmpd_pkg::LAST_COL);

  // scan result including this column
  always_comb begin
    result.found = found_r | hit;
    result.code  = hit ? {hit_row, col_r} : code_r;
  end

  // next state: restart after the last column
  always_comb begin
    col_nxt   = col_r;
    found_nxt = found_r;
    code_nxt  = code_r;
    if (beat) begin
      if (last_col) begin
        col_nxt   = '0;
        found_nxt = 1'b0;
        code_nxt  = '0;
      end else begin
        col_nxt   = col_r + 1'b1;
        found_nxt = result.found;
        code_nxt  = result.code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      found_r <= 1'b0;
      code_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      found_r <= found_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule
